[sv/hard_sphere_box_collision_step_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hard sphere box collision step unit
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HARD_SPHERE_BOX_COLLISION_STEP_UNIT_DEFINES_SVH
`define HARD_SPHERE_BOX_COLLISION_STEP_UNIT_DEFINES_SVH

// hold a stalled payload until it is taken
`define HSB_ASSERT_HOLD(label, clk, rst_n, vld, stl, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> $stable(sig)) else $error("payload changed under stall");

// same-cycle implication outside reset
`define HSB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> (cons)) else $error("implication failed");

// next-cycle implication that also covers reset
`define HSB_ASSERT_NEXT_RAW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[sv/hsb_pkg.sv]
// ----------------------------------------------------------------------------
// hsb_pkg
// Widths, codes, command and status types and saturation helpers.
// ----------------------------------------------------------------------------
package hsb_pkg;

  localparam int POS_W    = 24;
  localparam int VEL_W    = 20;
  localparam int DT_W     = 16;
  localparam int BOX_W    = 12;
  localparam int RAD_W    = 10;
  localparam int CNT_W    = 5;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 3;
  localparam int IDX_W    = 4;

  localparam int AX_W   = POS_W + 1;
  localparam int DV_W   = VEL_W + 1;
  localparam int DP_W   = AX_W + DV_W;
  localparam int D_W    = DP_W + 1;
  localparam int N_W    = 2 * AX_W + 1;
  localparam int Q_W    = DV_W + 1;
  localparam int VSUM_W = Q_W + 3;
  localparam int PSUM_W = VEL_W + DT_W + 2;
  localparam int WALL_W = POS_W + 2;

  localparam int POS_HI = (1 << (POS_W - 1)) - 1;
  localparam int POS_LO = -(1 << (POS_W - 1));
  localparam int VEL_HI = (1 << (VEL_W - 1)) - 1;
  localparam int VEL_LO = -(1 << (VEL_W - 1));

  localparam logic [BOX_W-1:0] RST_BOX_W  = 12'd800;
  localparam logic [BOX_W-1:0] RST_BOX_H  = 12'd600;
  localparam logic [DT_W-1:0]  RST_DT     = 16'd256;
  localparam logic [RAD_W-1:0] RST_RADIUS = 10'd40;
  localparam logic [CNT_W-1:0] RST_COUNT  = 5'd16;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_BOX_WIDTH  = 3'd0,
    CFG_BOX_HEIGHT = 3'd1,
    CFG_TIME_STEP  = 3'd2,
    CFG_RADIUS     = 3'd3,
    CFG_COUNT      = 3'd4
  } hsb_cfg_ix_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    WS_NONE   = 3'd0,
    WS_LOAD   = 3'd1,
    WS_WALL   = 3'd2,
    WS_PAIR_I = 3'd3,
    WS_PAIR_J = 3'd4,
    WS_POS    = 3'd5
  } hsb_wsel_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } hsb_sphere_t;

  typedef struct packed {
    logic      rd_en;
    hsb_wsel_t wsel;
    logic      latch_a;
    logic      latch_b;
    logic      diff_en;
    logic      prod_en;
    logic      sum_en;
    logic      md_start;
    logic      out_last;
  } hsb_cmd_t;

  typedef struct packed {
    logic collide;
    logic md_done;
    logic out_free;
  } hsb_status_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VSUM_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v > VEL_HI) r = VEL_W'(VEL_HI);
    else if (v < VEL_LO) r = VEL_W'(VEL_LO);
    else r = v[VEL_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W-1:0] r;
    if (v == VEL_W'(VEL_LO)) r = VEL_W'(VEL_HI);
    else r = -v;
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PSUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_HI) r = POS_W'(POS_HI);
    else if (v < POS_LO) r = POS_W'(POS_LO);
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage

[sv/hsb_muldiv.sv]
// ----------------------------------------------------------------------------
// hsb_muldiv
// Serial (a*d)/n, truncated toward zero: shift-add multiply, then restoring
// division over the quotient bits.
// ----------------------------------------------------------------------------
module hsb_muldiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [hsb_pkg::AX_W-1:0] a,
  input  logic signed [hsb_pkg::D_W-1:0]  d,
  input  logic        [hsb_pkg::N_W-1:0]  n,
  output logic                          done,
  output logic signed [hsb_pkg::Q_W:0]    q
);
  import hsb_pkg::*;

  localparam int P_W  = AX_W + D_W;
  localparam int SC_W = $clog2(AX_W + 1);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

  md_state_t         state_r, state_nxt;
  logic [SC_W-1:0]   step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [AX_W-1:0]   ma_r;
  logic [D_W-1:0]    md_r;
  logic [P_W-1:0]    acc_r;
  logic [N_W-1:0]    rem_r;
  logic [Q_W-1:0]    qa_r;
  logic              neg_r;
  logic [N_W:0]      trial;
  logic              ge;

  assign trial = {rem_r, acc_r[Q_W-1]};
  assign ge    = (trial >= (N_W + 1)'(n));

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      MD_IDLE: begin
        if (start) begin
          state_nxt = MD_MUL;
          step_nxt  = SC_W'(AX_W - 1);
        end
      end
      MD_MUL: begin
        if (step_r == '0) begin
          state_nxt = MD_DIV;
          step_nxt  = SC_W'(Q_W - 1);
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      MD_DIV: begin
        if (step_r == '0) begin
          state_nxt = MD_IDLE;
          done_nxt  = 1'b1;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MD_IDLE: begin
        if (start) begin
          ma_r  <= a[AX_W-1] ? AX_W'(-a) : AX_W'(a);
          md_r  <= d[D_W-1] ? D_W'(-d) : D_W'(d);
          neg_r <= a[AX_W-1] ^ d[D_W-1];
          acc_r <= '0;
        end
      end
      MD_MUL: begin
        acc_r <= (acc_r << 1) + (ma_r[AX_W-1] ? P_W'(md_r) : '0);
        ma_r  <= ma_r << 1;
        // quotient stays below 2^Q_W, so the high part is already below n
        if (step_r == '0) begin
          rem_r <= N_W'(((acc_r << 1) + (ma_r[AX_W-1] ? P_W'(md_r) : '0)) >> Q_W);
          qa_r  <= '0;
        end
      end
      MD_DIV: begin
        rem_r <= ge ? N_W'(trial - (N_W + 1)'(n)) : trial[N_W-1:0];
        acc_r <= acc_r << 1;
        qa_r  <= {qa_r[Q_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign q    = neg_r ? -$signed({1'b0, qa_r}) : $signed({1'b0, qa_r});

endmodule

[sv/hsb_datapath.sv]
// ----------------------------------------------------------------------------
// hsb_datapath
// Sphere memory, configuration registers, wall, pair and position arithmetic
// and the result register.
// ----------------------------------------------------------------------------
module hsb_datapath #(
  parameter int MAX_SPHERES   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hsb_pkg::hsb_cmd_t                 cmd,
  input  logic [$clog2(MAX_SPHERES)-1:0]    rd_addr,
  input  logic [$clog2(MAX_SPHERES)-1:0]    wr_addr,
  output hsb_pkg::hsb_status_t              status,
  output logic [$clog2(MAX_SPHERES+1)-1:0]  cnt,
  input  logic                              cfg_we,
  input  logic [hsb_pkg::CFG_IX_W-1:0]      cfg_index,
  input  logic [hsb_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [hsb_pkg::POS_W-1:0]  in_load_pos_x,
  input  logic signed [hsb_pkg::POS_W-1:0]  in_load_pos_y,
  input  logic signed [hsb_pkg::VEL_W-1:0]  in_load_vel_x,
  input  logic signed [hsb_pkg::VEL_W-1:0]  in_load_vel_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hsb_pkg::IDX_W-1:0]         out_index,
  output logic signed [hsb_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [hsb_pkg::POS_W-1:0]  out_pos_y,
  output logic                              out_last
);
  import hsb_pkg::*;

  localparam int AW    = $clog2(MAX_SPHERES);
  localparam int CW    = $clog2(MAX_SPHERES + 1);
  localparam int CMP_W = ((CW > CNT_W) ? CW : CNT_W) + 1;
  localparam int CT_W  = RAD_W + 1 + FRACTION_BITS;
  localparam int MX_W  = VEL_W + DT_W + 1;

  // configuration
  logic [BOX_W-1:0] box_w_r, box_h_r;
  logic [DT_W-1:0]  dt_r;
  logic [RAD_W-1:0] rad_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_w_r <= RST_BOX_W;
      box_h_r <= RST_BOX_H;
      dt_r    <= RST_DT;
      rad_r   <= RST_RADIUS;
      count_r <= RST_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_WIDTH:  box_w_r <= cfg_data[BOX_W-1:0];
        CFG_BOX_HEIGHT: box_h_r <= cfg_data[BOX_W-1:0];
        CFG_TIME_STEP:  dt_r    <= cfg_data[DT_W-1:0];
        CFG_RADIUS:     rad_r   <= cfg_data[RAD_W-1:0];
        CFG_COUNT:      count_r <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cnt = (CMP_W'(count_r) > CMP_W'(MAX_SPHERES)) ? CW'(MAX_SPHERES) : CW'(count_r);

  // sphere memory; an entry never written reads as zero
  hsb_sphere_t mem_r [MAX_SPHERES];
  logic [MAX_SPHERES-1:0] vld_r;
  hsb_sphere_t rd_q_r, rd_data, wr_data;
  logic        rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.wsel != WS_NONE) mem_r[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.wsel != WS_NONE) vld_r[wr_addr] <= 1'b1;
      if (cmd.rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

  // wall pass
  logic signed [WALL_W-1:0] r_s, bxr_s, byr_s, wpx_s, wpy_s;
  logic                     flip_x, flip_y;
  hsb_sphere_t              wall_word;

  assign r_s    = WALL_W'(rad_r) << FRACTION_BITS;
  assign bxr_s  = (WALL_W'(box_w_r) << FRACTION_BITS) - r_s;
  assign byr_s  = (WALL_W'(box_h_r) << FRACTION_BITS) - r_s;
  assign wpx_s  = WALL_W'(rd_data.px);
  assign wpy_s  = WALL_W'(rd_data.py);
  assign flip_x = (wpx_s > bxr_s) || (wpx_s < r_s);
  assign flip_y = (wpy_s > byr_s) || (wpy_s < r_s);

  always_comb begin
    wall_word    = rd_data;
    wall_word.vx = flip_x ? neg_vel(rd_data.vx) : rd_data.vx;
    wall_word.vy = flip_y ? neg_vel(rd_data.vy) : rd_data.vy;
  end

  // pair pass
  hsb_sphere_t               a_r, b_r;
  logic signed [AX_W-1:0]    ax_r, ay_r;
  logic signed [DV_W-1:0]    dvx_r, dvy_r;
  logic signed [2*AX_W-1:0]  ax2_r, ay2_r;
  logic signed [DP_W-1:0]    pxd_r, pyd_r;
  logic [2*CT_W-1:0]         csq_r;
  logic [CT_W-1:0]           contact;
  logic [N_W-1:0]            n_r, n_sum;
  logic signed [D_W-1:0]     d_r, d_sum;
  logic                      coll_r;

  assign contact = CT_W'(rad_r) << (FRACTION_BITS + 1);
  assign n_sum   = N_W'(ax2_r) + N_W'(ay2_r);
  assign d_sum   = D_W'(pxd_r) + D_W'(pyd_r);

  always_ff @(posedge clk) begin
    if (cmd.latch_a) a_r <= rd_data;
    if (cmd.latch_b) b_r <= rd_data;
    if (cmd.diff_en) begin
      ax_r  <= AX_W'(a_r.px) - AX_W'(b_r.px);
      ay_r  <= AX_W'(a_r.py) - AX_W'(b_r.py);
      dvx_r <= DV_W'(a_r.vx) - DV_W'(b_r.vx);
      dvy_r <= DV_W'(a_r.vy) - DV_W'(b_r.vy);
    end
    if (cmd.prod_en) begin
      ax2_r <= ax_r * ax_r;
      ay2_r <= ay_r * ay_r;
      pxd_r <= DP_W'(dvx_r) * DP_W'(ax_r);
      pyd_r <= DP_W'(dvy_r) * DP_W'(ay_r);
      csq_r <= (2*CT_W)'(contact) * (2*CT_W)'(contact);
    end
    if (cmd.sum_en) begin
      n_r    <= n_sum;
      d_r    <= d_sum;
      coll_r <= (n_sum != '0) && (n_sum < N_W'(csq_r)) && d_sum[D_W-1];
    end
  end

  logic               done_x, done_y;
  logic signed [Q_W:0] tx, ty;

  hsb_muldiv u_md_x (
    .clk(clk), .rst_n(rst_n), .start(cmd.md_start),
    .a(ax_r), .d(d_r), .n(n_r), .done(done_x), .q(tx)
  );

  hsb_muldiv u_md_y (
    .clk(clk), .rst_n(rst_n), .start(cmd.md_start),
    .a(ay_r), .d(d_r), .n(n_r), .done(done_y), .q(ty)
  );

  hsb_sphere_t pair_i_word, pair_j_word;

  always_comb begin
    pair_i_word    = a_r;
    pair_i_word.vx = sat_vel(VSUM_W'(a_r.vx) - VSUM_W'(tx));
    pair_i_word.vy = sat_vel(VSUM_W'(a_r.vy) - VSUM_W'(ty));
    pair_j_word    = b_r;
    pair_j_word.vx = sat_vel(VSUM_W'(b_r.vx) + VSUM_W'(tx));
    pair_j_word.vy = sat_vel(VSUM_W'(b_r.vy) + VSUM_W'(ty));
  end

  // position pass: p += floor(v*dt / 2^F)
  logic signed [MX_W-1:0] mx, my;
  hsb_sphere_t            pos_word;

  assign mx = rd_data.vx * $signed({1'b0, dt_r});
  assign my = rd_data.vy * $signed({1'b0, dt_r});

  always_comb begin
    pos_word    = rd_data;
    pos_word.px = sat_pos(PSUM_W'(rd_data.px) + PSUM_W'(mx >>> FRACTION_BITS));
    pos_word.py = sat_pos(PSUM_W'(rd_data.py) + PSUM_W'(my >>> FRACTION_BITS));
  end

  always_comb begin
    unique case (cmd.wsel)
      WS_LOAD:   wr_data = '{px: in_load_pos_x, py: in_load_pos_y,
                             vx: in_load_vel_x, vy: in_load_vel_y};
      WS_WALL:   wr_data = wall_word;
      WS_PAIR_I: wr_data = pair_i_word;
      WS_PAIR_J: wr_data = pair_j_word;
      WS_POS:    wr_data = pos_word;
      default:   wr_data = rd_data;
    endcase
  end

  // result register
  logic out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_index_r;
  logic signed [POS_W-1:0] out_px_r, out_py_r;
  logic out_last_r;
  logic out_load;

  assign out_load = (cmd.wsel == WS_POS);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= IDX_W'(wr_addr);
      out_px_r    <= pos_word.px;
      out_py_r    <= pos_word.py;
      out_last_r  <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_pos_x = out_px_r;
  assign out_pos_y = out_py_r;
  assign out_last  = out_last_r;

  assign status.collide  = coll_r;
  assign status.md_done  = done_x & done_y;
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

[sv/hsb_ctrl.sv]
// ----------------------------------------------------------------------------
// hsb_ctrl
// Sequencer for loads and ticks: wall pass, pair pass, position and
// result pass over the sphere memory.
// ----------------------------------------------------------------------------
module hsb_ctrl #(
  parameter int MAX_SPHERES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [hsb_pkg::IDX_W-1:0]         in_sphere_index,
  input  hsb_pkg::hsb_status_t              status,
  input  logic [$clog2(MAX_SPHERES+1)-1:0]  cnt,
  output hsb_pkg::hsb_cmd_t                 cmd,
  output logic [$clog2(MAX_SPHERES)-1:0]    rd_addr,
  output logic [$clog2(MAX_SPHERES)-1:0]    wr_addr
);
  import hsb_pkg::*;

  localparam int AW    = $clog2(MAX_SPHERES);
  localparam int CW    = $clog2(MAX_SPHERES + 1);
  localparam int IXC_W = ((CW > IDX_W) ? CW : IDX_W) + 1;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_W_RD   = 15'h0002,
    ST_W_WR   = 15'h0004,
    ST_P_RDI  = 15'h0008,
    ST_P_RDJ  = 15'h0010,
    ST_P_LB   = 15'h0020,
    ST_P_DIFF = 15'h0040,
    ST_P_PROD = 15'h0080,
    ST_P_SUM  = 15'h0100,
    ST_P_TEST = 15'h0200,
    ST_P_DIV  = 15'h0400,
    ST_P_WRI  = 15'h0800,
    ST_P_WRJ  = 15'h1000,
    ST_Q_RD   = 15'h2000,
    ST_Q_WR   = 15'h4000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]  cnt_m1, cnt_m2;
  logic           load_ok;

  assign cnt_m1  = cnt - 1'b1;
  assign cnt_m2  = cnt - 2'd2;
  assign load_ok = (IXC_W'(in_sphere_index) < IXC_W'(MAX_SPHERES));
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cmd       = '0;
    cmd.wsel  = WS_NONE;
    rd_addr   = '0;
    wr_addr   = '0;
    unique case (state_r)
      ST_IDLE: begin
        wr_addr = AW'(in_sphere_index);
        if (in_valid) begin
          if (in_mode == MODE_TICK) begin
            k_nxt = '0;
            if (cnt != '0) state_nxt = ST_W_RD;
          end else if (load_ok) begin
            cmd.wsel = WS_LOAD;
          end
        end
      end
      ST_W_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = k_r[AW-1:0];
        state_nxt = ST_W_WR;
      end
      ST_W_WR: begin
        cmd.wsel = WS_WALL;
        wr_addr  = k_r[AW-1:0];
        if (k_r == cnt_m1) begin
          k_nxt = '0;
          i_nxt = '0;
          j_nxt = CW'(1);
          state_nxt = (cnt >= CW'(2)) ? ST_P_RDI : ST_Q_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_W_RD;
        end
      end
      ST_P_RDI: begin
        cmd.rd_en = 1'b1;
        rd_addr   = i_r[AW-1:0];
        state_nxt = ST_P_RDJ;
      end
      ST_P_RDJ: begin
        cmd.rd_en   = 1'b1;
        cmd.latch_a = 1'b1;
        rd_addr     = j_r[AW-1:0];
        state_nxt   = ST_P_LB;
      end
      ST_P_LB: begin
        cmd.latch_b = 1'b1;
        state_nxt   = ST_P_DIFF;
      end
      ST_P_DIFF: begin
        cmd.diff_en = 1'b1;
        state_nxt   = ST_P_PROD;
      end
      ST_P_PROD: begin
        cmd.prod_en = 1'b1;
        state_nxt   = ST_P_SUM;
      end
      ST_P_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_P_TEST;
      end
      ST_P_TEST: begin
        if (status.collide) begin
          cmd.md_start = 1'b1;
          state_nxt    = ST_P_DIV;
        end else begin
          state_nxt = ST_P_WRJ;
        end
      end
      ST_P_DIV: begin
        if (status.md_done) state_nxt = ST_P_WRI;
      end
      ST_P_WRI: begin
        cmd.wsel  = WS_PAIR_I;
        wr_addr   = i_r[AW-1:0];
        state_nxt = ST_P_WRJ;
      end
      ST_P_WRJ: begin
        // a pair that did not collide passes here without a write
        if (!status.collide) begin
          cmd.wsel = WS_NONE;
        end else begin
          cmd.wsel = WS_PAIR_J;
        end
        wr_addr = j_r[AW-1:0];
        if (j_r == cnt_m1) begin
          if (i_r == cnt_m2) begin
            k_nxt     = '0;
            state_nxt = ST_Q_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            j_nxt     = i_r + 2'd2;
            state_nxt = ST_P_RDI;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_P_RDI;
        end
      end
      ST_Q_RD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = k_r[AW-1:0];
        state_nxt = ST_Q_WR;
      end
      ST_Q_WR: begin
        wr_addr      = k_r[AW-1:0];
        cmd.out_last = (k_r == cnt_m1);
        if (status.out_free) begin
          cmd.wsel = WS_POS;
          if (k_r == cnt_m1) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_Q_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

endmodule

[sv/hard_sphere_box_collision_step_unit.sv]
// ----------------------------------------------------------------------------
// hard_sphere_box_collision_step_unit
// Equal-mass hard spheres in a box: load, wall bounce, pair exchange, move.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a transaction with in_mode = load
// writes one sphere's position and velocity and gives no
// result. A transaction with in_mode = tick runs one update step.
// Result channel (out_valid / out_stall): a tick returns one transaction per
// sphere in use, in index order, out_last set on the final one.
// Tick sequence: a read and a write state per sphere for the wall pass, then
// for each pair (i<j) the overlap test; each colliding pair also waits on
// the serial multiply-divide unit (25 multiply steps and 22 quotient steps)
// and writes both spheres back. Then a read and a write state per sphere
// to move and emit it.
// in_stall stays high from a tick's acceptance until its last result is in
// the output register. A stalled receiver holds the result register and
// the pass waits on it.
// Reset clears the valid bit of every memory entry, so all spheres read as
// zero, and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module hard_sphere_box_collision_step_unit #(
  parameter int MAX_SPHERES   = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [hsb_pkg::IDX_W-1:0]         in_sphere_index,
  input  logic signed [hsb_pkg::POS_W-1:0]  in_load_pos_x,
  input  logic signed [hsb_pkg::POS_W-1:0]  in_load_pos_y,
  input  logic signed [hsb_pkg::VEL_W-1:0]  in_load_vel_x,
  input  logic signed [hsb_pkg::VEL_W-1:0]  in_load_vel_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hsb_pkg::IDX_W-1:0]         out_index,
  output logic signed [hsb_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [hsb_pkg::POS_W-1:0]  out_pos_y,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [hsb_pkg::CFG_IX_W-1:0]      cfg_index,
  input  logic [hsb_pkg::CFG_W-1:0]         cfg_data
);
  import hsb_pkg::*;

  localparam int AW = $clog2(MAX_SPHERES);
  localparam int CW = $clog2(MAX_SPHERES + 1);

  hsb_cmd_t    cmd;
  hsb_status_t status;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] cnt;

  hsb_ctrl #(.MAX_SPHERES(MAX_SPHERES)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_sphere_index(in_sphere_index),
    .status(status), .cnt(cnt), .cmd(cmd),
    .rd_addr(rd_addr), .wr_addr(wr_addr)
  );

  hsb_datapath #(.MAX_SPHERES(MAX_SPHERES), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .rd_addr(rd_addr), .wr_addr(wr_addr),
    .status(status), .cnt(cnt),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_load_pos_x(in_load_pos_x), .in_load_pos_y(in_load_pos_y),
    .in_load_vel_x(in_load_vel_x), .in_load_vel_y(in_load_vel_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_index(out_index),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_last(out_last)
  );

endmodule

[sv/hsb_checker.sv]
// ----------------------------------------------------------------------------
// hsb_checker
// Port-level checks on the result channel and input back-pressure.
// ----------------------------------------------------------------------------
`include "hard_sphere_box_collision_step_unit_defines.svh"

module hsb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [hsb_pkg::IDX_W-1:0]         out_index,
  input logic signed [hsb_pkg::POS_W-1:0]  out_pos_x,
  input logic signed [hsb_pkg::POS_W-1:0]  out_pos_y,
  input logic                              out_last
);

  `HSB_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_stall, {out_index, out_pos_x, out_pos_y, out_last})

  `HSB_ASSERT_IMPL(a_busy_mid_run, clk, rst_n, out_valid && !out_last, in_stall)

  `HSB_ASSERT_NEXT_RAW(a_reset_quiet, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind hard_sphere_box_collision_step_unit hsb_checker u_hsb_checker (.*);
